[sv/wrs_pkg.sv]
// Package for the weighted roulette selector: command codes and fixed field widths.
// It has no dependencies. The selector core uses its contents by scoped name.
package wrs_pkg;

	// Codes carried in the command field of an input word.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Fixed widths of the interface fields.
	localparam int INDEX_W    = 7;
	localparam int IN_WEIGHT_W = 16;
	localparam int COUNT_W    = 8;
	localparam int FRAC_W     = 32;
	localparam int FRAC_CNT_W = 5;

	// The entry count register comes out of reset at 128.
	localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 8'd128;

endpackage

[sv/wrs_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies. The weighted roulette selector keeps its weight table in it.
module wrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/weighted_roulette_selector_core.sv]
// Weighted roulette selector core: a weight table in RAM and one shared adder under a sequencer.
// Depends on wrs_pkg for command codes and field widths, and on wrs_ram for the weight table.
// A sample sums the adjusted weights of the n active entries, multiplies the total by the
// fraction, scans for the hit and then finishes; the one adder and RAM read port are shared,
// so a new input word is taken only once the previous sample has finished.
// Reset: asynchronous, active low; the block then clears every RAM entry to zero before it takes input.
module weighted_roulette_selector_core #(
	parameter int MAX_ENTRIES = 128,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,

	// Configuration: the entry count register.
	input  logic                             cfg_write_en,
	input  logic [wrs_pkg::COUNT_W-1:0]      cfg_write_data,

	// Input words.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [wrs_pkg::INDEX_W-1:0]      entry_index,
	input  logic [wrs_pkg::IN_WEIGHT_W-1:0]  weight,
	input  logic [wrs_pkg::FRAC_W-1:0]       random_fraction,

	// Result words.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [wrs_pkg::INDEX_W-1:0]      selected_index
);

	// Address width of the table, and the width of counts and entry indices. The count
	// needs room for MAX_ENTRIES itself and for the raw 8-bit register value.
	localparam int AW     = $clog2(MAX_ENTRIES);
	localparam int NW_RAW = $clog2(MAX_ENTRIES + 1);
	localparam int NW     = (NW_RAW > wrs_pkg::COUNT_W) ? NW_RAW : wrs_pkg::COUNT_W;
	// An adjusted weight 5*w+1 needs three more bits than w. At most 255 entries take part,
	// so the total needs eight more. The product with the fraction adds the fraction width.
	localparam int AJ_W    = WEIGHT_BITS + 3;
	localparam int TOTAL_W = AJ_W + wrs_pkg::COUNT_W;
	localparam int PROD_W  = TOTAL_W + wrs_pkg::FRAC_W;
	// Helper widths for extending fixed-width ports before selecting the needed bits.
	localparam int IW = (AW > wrs_pkg::INDEX_W) ? AW : wrs_pkg::INDEX_W;
	localparam int WX = (WEIGHT_BITS > wrs_pkg::IN_WEIGHT_W) ? WEIGHT_BITS : wrs_pkg::IN_WEIGHT_W;
	localparam int PW = (NW > wrs_pkg::INDEX_W) ? NW : wrs_pkg::INDEX_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                clr_q;
	logic [wrs_pkg::COUNT_W-1:0]  entry_count_q;
	logic [NW-1:0]                last_q;
	logic [NW-1:0]                rd_q;
	logic [NW-1:0]                dk_q;
	logic                         dv_s1;
	logic [PROD_W-1:0]            acc_q;
	logic [TOTAL_W-1:0]           tot_q;
	logic [TOTAL_W-1:0]           thresh_q;
	logic [wrs_pkg::FRAC_W-1:0]   f_q;
	logic [wrs_pkg::FRAC_CNT_W-1:0] bit_q;
	logic [NW-1:0]                pick_q;
	logic                         out_valid_q;
	logic [wrs_pkg::INDEX_W-1:0]  sel_q;

	logic                         in_accept;
	logic                         wr_item;
	logic [IW-1:0]                idx_ext;
	logic [WX-1:0]                weight_ext;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [WEIGHT_BITS-1:0]       ram_wdata;
	logic [WEIGHT_BITS-1:0]       ram_rdata;
	logic [AJ_W-1:0]              adj;
	logic [PROD_W-1:0]            op_a;
	logic [PROD_W-1:0]            op_b;
	logic [PROD_W-1:0]            add_sum;
	logic                         hit;
	logic                         issue;
	logic [NW-1:0]                ec_ext;
	logic [NW-1:0]                n_active;
	logic [PW-1:0]                pick_ext;

	// New words are taken only when the sequencer is idle. A finished result may still be
	// waiting in the output register; only the next sample's finish waits for it.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// A write word stores its weight at once; indices beyond the table are dropped.
	assign wr_item    = in_accept && (command == wrs_pkg::CMD_WRITE) &&
	                    (32'(entry_index) < MAX_ENTRIES);
	assign idx_ext    = IW'(entry_index);
	assign weight_ext = WX'(weight);

	// During the clearing pass after reset the write port sweeps the table with zeros.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = wr_item;
			ram_waddr = idx_ext[AW-1:0];
			ram_wdata = weight_ext[WEIGHT_BITS-1:0];
		end
	end

	wrs_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// The active count is the register clamped into 1..MAX_ENTRIES.
	always_comb begin
		ec_ext = NW'(entry_count_q);
		if (ec_ext == '0) begin
			n_active = NW'(1);
		end else if (ec_ext > NW'(MAX_ENTRIES)) begin
			n_active = NW'(MAX_ENTRIES);
		end else begin
			n_active = ec_ext;
		end
	end

	// Adjusted weight 5*w + 1 of the word just read from the table.
	assign adj = (AJ_W'(ram_rdata) << 2) + AJ_W'(ram_rdata) + AJ_W'(1);

	// The one shared adder. While summing and scanning it accumulates adjusted weights.
	// While multiplying it runs a shift-and-add of the fraction, most significant bit first,
	// against the total.
	always_comb begin
		case (state_q)
			ST_MUL: begin
				op_a = acc_q << 1;
				op_b = f_q[wrs_pkg::FRAC_W-1] ? PROD_W'(tot_q) : '0;
			end
			default: begin
				op_a = acc_q;
				op_b = PROD_W'(adj);
			end
		endcase
	end
	assign add_sum = op_a + op_b;

	// The scan stops at the first running sum C with C*2^32 >= f*T. The threshold holds
	// the ceiling of f*T / 2^32, so the test is a plain compare.
	assign hit   = (add_sum >= PROD_W'(thresh_q));
	assign issue = (rd_q <= last_q);

	assign pick_ext = PW'(pick_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			entry_count_q <= wrs_pkg::ENTRY_COUNT_RESET;
			out_valid_q   <= 1'b0;
			dv_s1         <= 1'b0;
			rd_q          <= '0;
			dk_q          <= '0;
			bit_q         <= '0;
		end else begin
			if (cfg_write_en) begin
				entry_count_q <= cfg_write_data;
			end
			// The finish state loads the output register itself.
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (in_accept && (command == wrs_pkg::CMD_SAMPLE)) begin
						last_q  <= n_active - NW'(1);
						f_q     <= random_fraction;
						rd_q    <= '0;
						dk_q    <= '0;
						dv_s1   <= 1'b0;
						acc_q   <= '0;
						state_q <= ST_SUM;
					end
				end

				ST_SUM: begin
					// Reads are issued one a cycle; each word arrives in the following cycle.
					if (issue) begin
						rd_q <= rd_q + NW'(1);
					end
					if (dv_s1 && (dk_q == last_q)) begin
						tot_q   <= add_sum[TOTAL_W-1:0];
						acc_q   <= '0;
						bit_q   <= '0;
						dv_s1   <= 1'b0;
						state_q <= ST_MUL;
					end else begin
						dv_s1 <= issue;
						if (dv_s1) begin
							acc_q <= add_sum;
							dk_q  <= dk_q + NW'(1);
						end
					end
				end

				ST_MUL: begin
					f_q   <= f_q << 1;
					bit_q <= bit_q + wrs_pkg::FRAC_CNT_W'(1);
					if (bit_q == wrs_pkg::FRAC_CNT_W'(wrs_pkg::FRAC_W - 1)) begin
						thresh_q <= add_sum[PROD_W-1:wrs_pkg::FRAC_W] +
						            TOTAL_W'(|add_sum[wrs_pkg::FRAC_W-1:0]);
						acc_q    <= '0;
						rd_q     <= '0;
						dk_q     <= '0;
						dv_s1    <= 1'b0;
						state_q  <= ST_SCAN;
					end else begin
						acc_q <= add_sum;
					end
				end

				ST_SCAN: begin
					if (issue) begin
						rd_q <= rd_q + NW'(1);
					end
					// With no hit the last active entry is the answer, which is the
					// same index as the word in hand.
					if (dv_s1 && (hit || (dk_q == last_q))) begin
						pick_q  <= dk_q;
						dv_s1   <= 1'b0;
						state_q <= ST_FINISH;
					end else begin
						dv_s1 <= issue;
						if (dv_s1) begin
							acc_q <= add_sum;
							dk_q  <= dk_q + NW'(1);
						end
					end
				end

				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						sel_q       <= pick_ext[wrs_pkg::INDEX_W-1:0];
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign selected_index = sel_q;

endmodule
